// ===== hdl/lpds_pkg.sv =====
package lpds_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int TRIG_ITERS_DEF = 16;

    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int STAMP_W    = 52;
    localparam int SPAN_W     = 32;
    localparam int QUAT_W     = 64;
    localparam int QCOMP_W    = 16;
    localparam int ANGLE_W    = 16;

    // t in Q1.30, 0 .. 1.0
    localparam int FRAC_W = 31;
    localparam logic [FRAC_W-1:0] FRAC_ONE = 31'h4000_0000;

    // CORDIC datapath, Q2.30 with headroom
    localparam int TRIG_W = 34;
    localparam logic signed [TRIG_W-1:0] TRIG_ONE = 34'sd1073741824;

    localparam int DIV_STEPS = 30;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIME_END    = 3'd0,
        REG_INV_SPAN    = 3'd1,
        REG_TRANS_X     = 3'd2,
        REG_TRANS_Y     = 3'd3,
        REG_TRANS_Z     = 3'd4,
        REG_REL_QUAT    = 3'd5,
        REG_SLERP_ANGLE = 3'd6,
        REG_ROTATE_MODE = 3'd7
    } cfg_reg_t;

    localparam logic [29:0] ATAN_TAB [0:31] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
        30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
        30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
        30'd262143,    30'd131071,    30'd65535,     30'd32767,
        30'd16383,     30'd8191,      30'd4095,      30'd2047,
        30'd1023,      30'd511,       30'd255,       30'd127,
        30'd63,        30'd31,        30'd15,        30'd7,
        30'd3,         30'd1,         30'd0,         30'd0
    };

endpackage

// ===== hdl/lpds_cordic.sv =====
module lpds_cordic
    import lpds_pkg::*;
#(
    parameter int TRIG_ITERS = TRIG_ITERS_DEF
)
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [TRIG_W-1:0] ang,
    output logic signed [TRIG_W-1:0] sin_out
);

    logic signed [TRIG_W-1:0] x_reg [TRIG_ITERS];
    logic signed [TRIG_W-1:0] y_reg [TRIG_ITERS];
    logic signed [TRIG_W-1:0] z_reg [TRIG_ITERS];

    for (genvar i = 0; i < TRIG_ITERS; i++)
    begin : g_stage
        logic signed [TRIG_W-1:0] xi, yi, zi, dx, dy, at;
        if (i == 0)
        begin : g_first
            assign xi = TRIG_ONE;
            assign yi = '0;
            assign zi = ang;
        end
        else
        begin : g_rest
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign zi = z_reg[i-1];
        end
        assign dx = yi >>> i;
        assign dy = xi >>> i;
        assign at = $signed({4'b0000, ATAN_TAB[i]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!zi[TRIG_W-1])
                begin
                    x_reg[i] <= xi - dx;
                    y_reg[i] <= yi + dy;
                    z_reg[i] <= zi - at;
                end
                else
                begin
                    x_reg[i] <= xi + dx;
                    y_reg[i] <= yi - dy;
                    z_reg[i] <= zi + at;
                end
            end
        end
    end

    assign sin_out = y_reg[TRIG_ITERS-1];

endmodule

// ===== hdl/lpds_div.sv =====
module lpds_div
    import lpds_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [TRIG_W-1:0] num,
    input  logic signed [TRIG_W-1:0] den,
    output logic [FRAC_W-1:0]        quo
);

    logic                 neg_reg [DIV_STEPS+1];
    logic                 ge_reg  [DIV_STEPS+1];
    logic [TRIG_W-1:0]    rem_reg [DIV_STEPS+1];
    logic [TRIG_W-1:0]    den_reg [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] q_reg   [DIV_STEPS+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg[0] <= num[TRIG_W-1];
            ge_reg[0]  <= (num >= den);
            rem_reg[0] <= $unsigned(num);
            den_reg[0] <= $unsigned(den);
            q_reg[0]   <= '0;
        end
    end

    for (genvar k = 1; k <= DIV_STEPS; k++)
    begin : g_step
        logic [TRIG_W-1:0] shl, dif;
        logic              take;
        assign shl  = {rem_reg[k-1][TRIG_W-2:0], 1'b0};
        assign take = (shl >= den_reg[k-1]);
        assign dif  = shl - den_reg[k-1];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= take ? dif : shl;
                q_reg[k]   <= {q_reg[k-1][DIV_STEPS-2:0], take};
                neg_reg[k] <= neg_reg[k-1];
                ge_reg[k]  <= ge_reg[k-1];
                den_reg[k] <= den_reg[k-1];
            end
        end
    end

    assign quo = neg_reg[DIV_STEPS] ? '0 :
                 ge_reg[DIV_STEPS]  ? FRAC_ONE : {1'b0, q_reg[DIV_STEPS]};

endmodule

// ===== hdl/lidar_point_deskew_slerp_top.sv =====
// Throughput: one point per cycle; the whole pipeline advances unless the output
// register holds a result that is not taken.
// Depth is set by the CORDIC chain (TRIG_ITERS stages) and the 30-step weight divider.
// Reset clears the configuration registers and all pipeline valid bits.
module lidar_point_deskew_slerp_top
    import lpds_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int TRIG_ITERS = TRIG_ITERS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] pos_x,
    input  logic signed [COORD_BITS-1:0] pos_y,
    input  logic signed [COORD_BITS-1:0] pos_z,
    input  logic [STAMP_W-1:0]           stamp,
    input  logic                         point_ok,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COORD_BITS-1:0] out_x,
    output logic signed [COORD_BITS-1:0] out_y,
    output logic signed [COORD_BITS-1:0] out_z,
    output logic                         out_ok
);

    localparam int C_IDX  = 3 + TRIG_ITERS;
    localparam int D_IDX  = C_IDX + DIV_STEPS + 1;
    localparam int F_IDX  = D_IDX + 6;
    localparam int TRP_W  = FRAC_W + 1 + COORD_BITS;
    localparam int RMP_W  = TRIG_W + COORD_BITS;
    localparam int RP_W   = RMP_W - 30;
    localparam int SUM_W  = COORD_BITS + 7;
    localparam int BL_W   = 36;
    localparam logic signed [BL_W-1:0]   BL_ONE = 36'sd1073741824;
    localparam logic signed [TRIG_W-1:0] R_ONE  = 34'sd1073741824;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic signed [COORD_BITS-1:0] pz;
        logic                         ok;
        logic                         t_zero;
        logic                         t_one;
        logic [FRAC_W-1:0]            t;
        logic signed [COORD_BITS-1:0] tr_x;
        logic signed [COORD_BITS-1:0] tr_y;
        logic signed [COORD_BITS-1:0] tr_z;
        logic                         fb;
    } side_t;

    function automatic logic signed [31:0] clamp_q30(input logic signed [BL_W-1:0] v);
        logic signed [31:0] r;
        if (v > BL_ONE)
            r = 32'sd1073741824;
        else if (v < -BL_ONE)
            r = -32'sd1073741824;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] mul30(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        return p[61:30];
    endfunction

    function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [SUM_W-1:0] v);
        logic signed [COORD_BITS-1:0] r;
        if ((&v[SUM_W-1:COORD_BITS-1]) || !(|v[SUM_W-1:COORD_BITS-1]))
            r = v[COORD_BITS-1:0];
        else if (v[SUM_W-1])
            r = {1'b1, {(COORD_BITS-1){1'b0}}};
        else
            r = {1'b0, {(COORD_BITS-1){1'b1}}};
        return r;
    endfunction

    // configuration
    logic [STAMP_W-1:0]           time_end_reg;
    logic [SPAN_W-1:0]            inv_span_reg;
    logic signed [COORD_BITS-1:0] trans_x_reg, trans_y_reg, trans_z_reg;
    logic [QUAT_W-1:0]            rel_quat_reg;
    logic [ANGLE_W-1:0]           slerp_angle_reg;
    logic                         rotate_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_end_reg    <= '0;
            inv_span_reg    <= '0;
            trans_x_reg     <= '0;
            trans_y_reg     <= '0;
            trans_z_reg     <= '0;
            rel_quat_reg    <= '0;
            slerp_angle_reg <= '0;
            rotate_mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TIME_END:    time_end_reg    <= cfg_wdata[STAMP_W-1:0];
                REG_INV_SPAN:    inv_span_reg    <= cfg_wdata[SPAN_W-1:0];
                REG_TRANS_X:     trans_x_reg     <= cfg_wdata[COORD_BITS-1:0];
                REG_TRANS_Y:     trans_y_reg     <= cfg_wdata[COORD_BITS-1:0];
                REG_TRANS_Z:     trans_z_reg     <= cfg_wdata[COORD_BITS-1:0];
                REG_REL_QUAT:    rel_quat_reg    <= cfg_wdata[QUAT_W-1:0];
                REG_SLERP_ANGLE: slerp_angle_reg <= cfg_wdata[ANGLE_W-1:0];
                REG_ROTATE_MODE: rotate_mode_reg <= cfg_wdata[0];
                default:         rotate_mode_reg <= rotate_mode_reg;
            endcase
        end
    end

    // pipeline control
    logic [F_IDX:0] v_reg;
    logic           en;

    assign en        = !v_reg[F_IDX] || out_ready;
    assign in_ready  = en;
    assign out_valid = v_reg[F_IDX];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[F_IDX-1:0], in_valid};
    end

    // side data line
    side_t sb_reg  [F_IDX];
    side_t sb_next [F_IDX-1];
    side_t sb_in;

    logic [STAMP_W-1:0] diff_full;
    logic [SPAN_W-1:0]  diff_reg;
    logic [63:0]        prod_reg;
    logic [FRAC_W-1:0]  t_calc;

    assign diff_full = time_end_reg - stamp;

    always_comb
    begin
        sb_in        = '0;
        sb_in.px     = pos_x;
        sb_in.py     = pos_y;
        sb_in.pz     = pos_z;
        sb_in.ok     = point_ok;
        sb_in.t_zero = (stamp > time_end_reg) || (inv_span_reg == '0);
        sb_in.t_one  = |diff_full[STAMP_W-1:SPAN_W];
    end

    always_comb
    begin
        if (sb_reg[1].t_zero)
            t_calc = '0;
        else if (sb_reg[1].t_one || (|prod_reg[63:32]))
            t_calc = FRAC_ONE;
        else
            t_calc = {1'b0, prod_reg[31:2]};
    end

    // translation and slerp angles
    logic [29:0]              aq;
    logic [FRAC_W-1:0]        omt;
    logic [60:0]              a0_prod, a1_prod;
    logic signed [FRAC_W:0]   t_s;
    logic signed [TRP_W-1:0]  trx_p, try_p, trz_p;
    logic signed [TRIG_W-1:0] ang0_reg, ang1_reg, anga_reg;

    assign aq      = {slerp_angle_reg, 14'b0};
    assign omt     = FRAC_ONE - sb_reg[2].t;
    assign a0_prod = 61'(omt) * 61'(aq);
    assign a1_prod = 61'(sb_reg[2].t) * 61'(aq);
    assign t_s     = $signed({1'b0, sb_reg[2].t});
    assign trx_p   = TRP_W'(t_s) * TRP_W'(trans_x_reg);
    assign try_p   = TRP_W'(t_s) * TRP_W'(trans_y_reg);
    assign trz_p   = TRP_W'(t_s) * TRP_W'(trans_z_reg);

    // sines and weights
    logic signed [TRIG_W-1:0] sa_w, s0_w, s1_w;
    logic [FRAC_W-1:0]        q0_w, q1_w;

    lpds_cordic #(.TRIG_ITERS(TRIG_ITERS)) u_cordic_a
    (
        .clk     (clk),
        .en      (en),
        .ang     (anga_reg),
        .sin_out (sa_w)
    );

    lpds_cordic #(.TRIG_ITERS(TRIG_ITERS)) u_cordic_0
    (
        .clk     (clk),
        .en      (en),
        .ang     (ang0_reg),
        .sin_out (s0_w)
    );

    lpds_cordic #(.TRIG_ITERS(TRIG_ITERS)) u_cordic_1
    (
        .clk     (clk),
        .en      (en),
        .ang     (ang1_reg),
        .sin_out (s1_w)
    );

    lpds_div u_div_0
    (
        .clk (clk),
        .en  (en),
        .num (s0_w),
        .den (sa_w),
        .quo (q0_w)
    );

    lpds_div u_div_1
    (
        .clk (clk),
        .en  (en),
        .num (s1_w),
        .den (sa_w),
        .quo (q1_w)
    );

    always_comb
    begin
        for (int k = 0; k < F_IDX - 1; k++)
            sb_next[k] = sb_reg[k];
        sb_next[1].t     = t_calc;
        sb_next[2].tr_x  = trx_p[COORD_BITS+29:30];
        sb_next[2].tr_y  = try_p[COORD_BITS+29:30];
        sb_next[2].tr_z  = trz_p[COORD_BITS+29:30];
        sb_next[C_IDX].fb = (slerp_angle_reg == '0) || sa_w[TRIG_W-1] || (sa_w == '0);
    end

    // blend, rotation matrix, rotation
    logic [FRAC_W-1:0]          c0_reg, c1_reg;
    logic signed [31:0]         qw_reg, qx_reg, qy_reg, qz_reg;
    logic signed [31:0]         pr_reg [9];
    logic signed [TRIG_W-1:0]   rm_reg [9];
    logic signed [RP_W-1:0]     rp_reg [9];
    logic signed [FRAC_W:0]     c1_s;
    logic signed [47:0]         bw_p, bx_p, by_p, bz_p;
    logic signed [TRIG_W-1:0]   pr34 [9];
    logic signed [RMP_W-1:0]    rm_p [9];
    logic signed [COORD_BITS-1:0] pv [3];

    assign c1_s = $signed({1'b0, c1_reg});
    assign bw_p = 48'(c1_s) * 48'($signed(rel_quat_reg[63:48]));
    assign bx_p = 48'(c1_s) * 48'($signed(rel_quat_reg[47:32]));
    assign by_p = 48'(c1_s) * 48'($signed(rel_quat_reg[31:16]));
    assign bz_p = 48'(c1_s) * 48'($signed(rel_quat_reg[15:0]));

    assign pv[0] = sb_reg[D_IDX+4].px;
    assign pv[1] = sb_reg[D_IDX+4].py;
    assign pv[2] = sb_reg[D_IDX+4].pz;

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            pr34[k] = TRIG_W'(pr_reg[k]);
            rm_p[k] = RMP_W'(rm_reg[k]) * RMP_W'(pv[k % 3]);
        end
    end

    // final sums
    logic signed [SUM_W-1:0]      rot_x, rot_y, rot_z, lin_x, lin_y, lin_z;
    logic signed [COORD_BITS-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic signed [COORD_BITS-1:0] out_x_next, out_y_next, out_z_next;
    logic                         out_ok_reg;
    side_t                        sf;

    assign sf    = sb_reg[F_IDX-1];
    assign rot_x = SUM_W'(rp_reg[0]) + SUM_W'(rp_reg[1]) + SUM_W'(rp_reg[2]) + SUM_W'(sf.tr_x);
    assign rot_y = SUM_W'(rp_reg[3]) + SUM_W'(rp_reg[4]) + SUM_W'(rp_reg[5]) + SUM_W'(sf.tr_y);
    assign rot_z = SUM_W'(rp_reg[6]) + SUM_W'(rp_reg[7]) + SUM_W'(rp_reg[8]) + SUM_W'(sf.tr_z);
    assign lin_x = SUM_W'(sf.px) + SUM_W'(sf.tr_x);
    assign lin_y = SUM_W'(sf.py) + SUM_W'(sf.tr_y);
    assign lin_z = SUM_W'(sf.pz) + SUM_W'(sf.tr_z);

    always_comb
    begin
        if (!sf.ok)
        begin
            out_x_next = sf.px;
            out_y_next = sf.py;
            out_z_next = sf.pz;
        end
        else if (rotate_mode_reg)
        begin
            out_x_next = sat(rot_x);
            out_y_next = sat(rot_y);
            out_z_next = sat(rot_z);
        end
        else
        begin
            out_x_next = sat(lin_x);
            out_y_next = sat(lin_y);
            out_z_next = sat(lin_z);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_reg[0] <= sb_in;
            for (int k = 1; k < F_IDX; k++)
                sb_reg[k] <= sb_next[k-1];

            diff_reg <= diff_full[SPAN_W-1:0];
            prod_reg <= 64'(diff_reg) * 64'(inv_span_reg);

            ang0_reg <= $signed({4'b0000, a0_prod[59:30]});
            ang1_reg <= $signed({4'b0000, a1_prod[59:30]});
            anga_reg <= $signed({4'b0000, aq});

            c0_reg <= sb_reg[D_IDX].fb ? (FRAC_ONE - sb_reg[D_IDX].t) : q0_w;
            c1_reg <= sb_reg[D_IDX].fb ? sb_reg[D_IDX].t : q1_w;

            qw_reg <= clamp_q30(BL_W'($signed({5'b0, c0_reg})) + BL_W'($signed(bw_p[47:14])));
            qx_reg <= clamp_q30(BL_W'($signed(bx_p[47:14])));
            qy_reg <= clamp_q30(BL_W'($signed(by_p[47:14])));
            qz_reg <= clamp_q30(BL_W'($signed(bz_p[47:14])));

            pr_reg[0] <= mul30(qx_reg, qx_reg);
            pr_reg[1] <= mul30(qy_reg, qy_reg);
            pr_reg[2] <= mul30(qz_reg, qz_reg);
            pr_reg[3] <= mul30(qx_reg, qy_reg);
            pr_reg[4] <= mul30(qx_reg, qz_reg);
            pr_reg[5] <= mul30(qy_reg, qz_reg);
            pr_reg[6] <= mul30(qx_reg, qw_reg);
            pr_reg[7] <= mul30(qy_reg, qw_reg);
            pr_reg[8] <= mul30(qz_reg, qw_reg);

            rm_reg[0] <= R_ONE - ((pr34[1] + pr34[2]) <<< 1);
            rm_reg[1] <= (pr34[3] - pr34[8]) <<< 1;
            rm_reg[2] <= (pr34[4] + pr34[7]) <<< 1;
            rm_reg[3] <= (pr34[3] + pr34[8]) <<< 1;
            rm_reg[4] <= R_ONE - ((pr34[0] + pr34[2]) <<< 1);
            rm_reg[5] <= (pr34[5] - pr34[6]) <<< 1;
            rm_reg[6] <= (pr34[4] - pr34[7]) <<< 1;
            rm_reg[7] <= (pr34[5] + pr34[6]) <<< 1;
            rm_reg[8] <= R_ONE - ((pr34[0] + pr34[1]) <<< 1);

            for (int k = 0; k < 9; k++)
                rp_reg[k] <= rm_p[k][RMP_W-1:30];

            out_x_reg  <= out_x_next;
            out_y_reg  <= out_y_next;
            out_z_reg  <= out_z_next;
            out_ok_reg <= sf.ok;
        end
    end

    assign out_x  = out_x_reg;
    assign out_y  = out_y_reg;
    assign out_z  = out_z_reg;
    assign out_ok = out_ok_reg;

`ifndef SYNTHESIS
    a_t_range : assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[2] |-> (sb_reg[2].t <= FRAC_ONE))
        else $error("fraction above one");

    a_weight_range : assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[D_IDX+1] |-> (c0_reg <= FRAC_ONE) && (c1_reg <= FRAC_ONE))
        else $error("slerp weight above one");

    a_quat_range : assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[D_IDX+2] |-> (qw_reg <= 32'sd1073741824) && (qw_reg >= -32'sd1073741824))
        else $error("blended quaternion out of range");

    a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[F_IDX] && !out_ready) |=> $stable(v_reg))
        else $error("pipeline moved while stalled");
`endif

endmodule
